// File: design/som_pkg.sv
// ----------------------------------------------------------------------------
// som_pkg
// Shared types and constants for the self-organizing map search/update block.
// ----------------------------------------------------------------------------
package som_pkg;

   localparam int MAX_NEURONS = 64;
   localparam int VECTOR_LEN  = 4;
   localparam int IDX_W       = $clog2(MAX_NEURONS);
   localparam int CNT_W       = $clog2(MAX_NEURONS + 1);
   localparam int COMP_W      = 16;
   localparam int WORD_W      = COMP_W * VECTOR_LEN;
   localparam int DIST_W      = 34;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [1:0] CMD_WRITE    = 2'd0;
   localparam logic [1:0] CMD_TRAIN    = 2'd1;
   localparam logic [1:0] CMD_CLASSIFY = 2'd2;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_NEURON_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = 3'd3;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [5:0]        neuron_index;
      logic [COMP_W-1:0] comp_0;
      logic [COMP_W-1:0] comp_1;
      logic [COMP_W-1:0] comp_2;
      logic [COMP_W-1:0] comp_3;
   } req_type;

   typedef struct packed {
      logic [5:0]        bmu_index;
      logic [6:0]        tie_count;
      logic [DIST_W-1:0] best_distance;
      logic [6:0]        neighbours_updated;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } tag_type;

endpackage

// File: design/som_cell.sv
// ----------------------------------------------------------------------------
// som_cell
// One neuron slot of the weight ring: loads directly or takes its neighbor.
// ----------------------------------------------------------------------------
module som_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  som_pkg::word_type nxt_w,
   input  logic              load_en,
   input  som_pkg::word_type load_w,
   output som_pkg::word_type w
);
   import som_pkg::*;

   word_type w_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         w_ff <= load_w;
      end else if (shift_en) begin
         w_ff <= nxt_w;
      end
   end

   assign w = w_ff;

endmodule

// File: design/som_dist.sv
// ----------------------------------------------------------------------------
// som_dist
// Two-stage squared Euclidean distance between sample and head weight.
// ----------------------------------------------------------------------------
module som_dist (
   input  logic                          clock,
   input  logic                          reset,
   input  som_pkg::word_type             sample,
   input  som_pkg::word_type             weight,
   input  som_pkg::tag_type              tag_in,
   output som_pkg::tag_type              tag_out,
   output logic [som_pkg::DIST_W-1:0]    dist_sum
);
   import som_pkg::*;

   logic [2*COMP_W-1:0] sq_in [VECTOR_LEN];
   logic [2*COMP_W-1:0] sq_ff [VECTOR_LEN];
   tag_type             t1_ff;
   tag_type             t2_ff;
   logic [DIST_W-1:0]   dist_ff;
   logic [DIST_W-1:0]   sum_in;

   always_comb begin
      logic [COMP_W-1:0] x;
      logic [COMP_W-1:0] wv;
      logic [COMP_W-1:0] d;
      for (int k = 0; k < VECTOR_LEN; k++) begin
         x  = sample[k*COMP_W +: COMP_W];
         wv = weight[k*COMP_W +: COMP_W];
         d  = (x >= wv) ? (x - wv) : (wv - x);
         sq_in[k] = d * d;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < VECTOR_LEN; k++) begin
         sum_in = sum_in + DIST_W'(sq_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff.valid <= 1'b0;
         t2_ff.valid <= 1'b0;
      end else begin
         t1_ff.valid <= tag_in.valid;
         t2_ff.valid <= t1_ff.valid;
      end
      t1_ff.idx <= tag_in.idx;
      t1_ff.row <= tag_in.row;
      t1_ff.col <= tag_in.col;
      t2_ff.idx <= t1_ff.idx;
      t2_ff.row <= t1_ff.row;
      t2_ff.col <= t1_ff.col;
      sq_ff     <= sq_in;
      dist_ff   <= sum_in;
   end

   assign tag_out  = t2_ff;
   assign dist_sum = dist_ff;

endmodule

// File: design/som_update.sv
// ----------------------------------------------------------------------------
// som_update
// Moves one weight vector toward the sample: w += floor(alpha*(x-w)/2^16).
// ----------------------------------------------------------------------------
module som_update (
   input  som_pkg::word_type    sample,
   input  som_pkg::word_type    weight,
   input  logic [15:0]          alpha,
   output som_pkg::word_type    moved
);
   import som_pkg::*;

   always_comb begin
      logic signed [COMP_W:0]     diff;
      logic signed [2*COMP_W+1:0] prod;
      logic [COMP_W-1:0]          wv;
      for (int k = 0; k < VECTOR_LEN; k++) begin
         wv   = weight[k*COMP_W +: COMP_W];
         diff = $signed({1'b0, sample[k*COMP_W +: COMP_W]}) - $signed({1'b0, wv});
         prod = $signed({1'b0, alpha}) * diff;
         moved[k*COMP_W +: COMP_W] = wv + prod[COMP_W +: COMP_W];
      end
   end

endmodule

// File: design/som_bmu_search_and_update.sv
// ----------------------------------------------------------------------------
// som_bmu_search_and_update
// Self-organizing map: best matching unit search and neighborhood training.
// ----------------------------------------------------------------------------
// Usage:
//   req_ beats carry a command. A write loads one neuron and gives no
//   rsp_ beat; command 3 is dropped the same way. Classify and train each
//   give one rsp_ beat. The weights sit in a ring of MAX_NEURONS cells
//   that rotates past one distance unit (search pass, then a drain) and,
//   for train, past one update unit (second pass).
//   One item is in flight at a time; req_ready is low while a pass runs and
//   while a result waits on rsp_. A stalled receiver holds the result and
//   blocks new beats. csr_ writes take effect at once; write only when idle.
//   Reset clears control and loads register defaults; weights are undefined
//   until written.
// ----------------------------------------------------------------------------
module som_bmu_search_and_update (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  som_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output som_pkg::rsp_type                rsp_payload,
   input  logic                            csr_we,
   input  logic [som_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [som_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import som_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [6:0]       ncount_ff, cols_ff;
   logic [3:0]       radius_ff;
   logic [15:0]      alpha_ff;
   word_type         smp_ff;
   logic [1:0]       cmd_ff;

   logic [DIST_W-1:0] best_d_ff;
   logic [IDX_W-1:0]  best_idx_ff, best_row_ff, best_col_ff;
   logic [6:0]        ties_ff;
   logic [6:0]        upd_ff, upd_in;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   word_type cell_w [MAX_NEURONS];
   word_type feed_w, moved_w, req_w;
   tag_type  tag_in, tag_out;
   logic [DIST_W-1:0] head_dist;

   logic [CNT_W-1:0] n_eff;
   logic [6:0]       cols_eff;
   logic [3:0]       r_eff;
   logic             accept, wr, shift_en, head_live, in_square, last;
   logic [IDX_W-1:0] dr, dc;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign wr        = accept && (req_payload.command == CMD_WRITE);
   assign req_w     = {req_payload.comp_3, req_payload.comp_2,
                       req_payload.comp_1, req_payload.comp_0};

   assign n_eff = (ncount_ff == 7'd0) ? CNT_W'(1) :
                  (CNT_W'(ncount_ff) > CNT_W'(MAX_NEURONS)) ? CNT_W'(MAX_NEURONS) :
                  CNT_W'(ncount_ff);
   assign cols_eff = (cols_ff == 7'd0) ? 7'd1 : cols_ff;
   assign r_eff    = radius_ff | 4'd1;

   assign shift_en  = (state_ff == ST_SEARCH) || (state_ff == ST_UPDATE);
   assign head_live = cnt_ff < n_eff;
   assign last      = cnt_ff == CNT_W'(MAX_NEURONS - 1);

   genvar j;
   generate
      for (j = 0; j < MAX_NEURONS; j++) begin : g_cell
         som_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .nxt_w    ((j == MAX_NEURONS - 1) ? feed_w : cell_w[(j + 1) % MAX_NEURONS]),
            .load_en  (wr && (req_payload.neuron_index == IDX_W'(j))),
            .load_w   (req_w),
            .w        (cell_w[j])
         );
      end
   endgenerate

   assign tag_in.valid = (state_ff == ST_SEARCH) && head_live;
   assign tag_in.idx   = cnt_ff[IDX_W-1:0];
   assign tag_in.row   = row_ff;
   assign tag_in.col   = col_ff;

   som_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .sample   (smp_ff),
      .weight   (cell_w[0]),
      .tag_in   (tag_in),
      .tag_out  (tag_out),
      .dist_sum (head_dist)
   );

   som_update u_update (
      .sample (smp_ff),
      .weight (cell_w[0]),
      .alpha  (alpha_ff),
      .moved  (moved_w)
   );

   assign dr = (row_ff >= best_row_ff) ? row_ff - best_row_ff : best_row_ff - row_ff;
   assign dc = (col_ff >= best_col_ff) ? col_ff - best_col_ff : best_col_ff - col_ff;
   assign in_square = (state_ff == ST_UPDATE) && head_live &&
                      (dr <= IDX_W'(r_eff)) && (dc <= IDX_W'(r_eff));
   assign feed_w = in_square ? moved_w : cell_w[0];
   assign upd_in = upd_ff + {6'd0, in_square};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + CNT_W'(1);
      row_in   = row_ff;
      col_in   = col_ff + IDX_W'(1);
      if (7'(col_ff) + 7'd1 == cols_eff) begin
         col_in = '0;
         row_in = row_ff + IDX_W'(1);
      end
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            row_in = '0;
            col_in = '0;
            if (accept && ((req_payload.command == CMD_TRAIN) ||
                           (req_payload.command == CMD_CLASSIFY))) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (last) begin
               state_in = ST_DRAIN;
               cnt_in   = '0;
            end
         end
         ST_DRAIN: begin
            row_in = '0;
            col_in = '0;
            if (cnt_ff == CNT_W'(2)) begin
               cnt_in   = '0;
               state_in = (cmd_ff == CMD_TRAIN) ? ST_UPDATE : ST_IDLE;
            end
         end
         ST_UPDATE: begin
            if (last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ncount_ff    <= 7'd64;
         cols_ff      <= 7'd10;
         radius_ff    <= 4'd1;
         alpha_ff     <= 16'd6554;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (((state_ff == ST_DRAIN) && (state_in == ST_IDLE)) ||
             ((state_ff == ST_UPDATE) && last)) begin
            rsp_valid_ff <= 1'b1;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_NEURON_COUNT:  ncount_ff <= csr_wdata[6:0];
               CSR_GRID_COLUMNS:  cols_ff   <= csr_wdata[6:0];
               CSR_RADIUS:        radius_ff <= csr_wdata[3:0];
               CSR_LEARNING_RATE: alpha_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         smp_ff <= req_w;
         cmd_ff <= req_payload.command;
         upd_ff <= '0;
      end else if (state_ff == ST_UPDATE) begin
         upd_ff <= upd_in;
      end
      if (tag_out.valid) begin
         if ((tag_out.idx == '0) || (head_dist < best_d_ff)) begin
            best_d_ff   <= head_dist;
            best_idx_ff <= tag_out.idx;
            best_row_ff <= tag_out.row;
            best_col_ff <= tag_out.col;
            ties_ff     <= 7'd1;
         end else if (head_dist == best_d_ff) begin
            ties_ff <= ties_ff + 7'd1;
         end
      end
      if ((state_ff == ST_DRAIN) && (state_in == ST_IDLE)) begin
         rsp_ff.bmu_index          <= 6'(best_idx_ff);
         rsp_ff.tie_count          <= ties_ff;
         rsp_ff.best_distance      <= best_d_ff;
         rsp_ff.neighbours_updated <= 7'd0;
      end
      if ((state_ff == ST_UPDATE) && last) begin
         rsp_ff.bmu_index          <= 6'(best_idx_ff);
         rsp_ff.tie_count          <= ties_ff;
         rsp_ff.best_distance      <= best_d_ff;
         rsp_ff.neighbours_updated <= upd_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
